>>> design/rgbmf_pkg.sv
// ----------------------------------------------------------------------------
// rgbmf_pkg
// Shared types and constants of the RGB window median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbmf_pkg;

    localparam int CHAN_W     = 8;   // one colour component
    localparam int POS_W      = 7;   // pos_x / pos_y
    localparam int DIM_W      = 8;   // img_width / img_height registers
    localparam int WIN_W      = 3;   // window_size register
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;
    localparam int DEF_MAX_WINDOW = 7;

    localparam logic [DIM_W-1:0] RST_IMG_WIDTH  = 8'd128;
    localparam logic [DIM_W-1:0] RST_IMG_HEIGHT = 8'd128;
    localparam logic [WIN_W-1:0] RST_WIN_SIZE   = 3'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_SIZE   = 2'd2;

    // operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic              op;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [CHAN_W-1:0] in_red;
        logic [CHAN_W-1:0] in_green;
        logic [CHAN_W-1:0] in_blue;
    } t_rgbmf_in;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
    } t_rgbmf_out;

    // what one sorting cell shows its neighbors
    typedef struct packed {
        logic              vld;
        logic [CHAN_W-1:0] val;
        logic              gt;   // empty, or holds a value above the new one
    } t_rgbmf_link;

    typedef struct packed {
        logic clr;   // empty every cell
        logic ins;   // insert the broadcast value
        logic shf;   // move every value one cell toward cell 0
    } t_rgbmf_ctl;

endpackage

`default_nettype wire

>>> design/rgbmf_cell.sv
// ----------------------------------------------------------------------------
// rgbmf_cell
// One cell of the insertion sorting chain; holds one sorted channel value.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbmf_cell (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  rgbmf_pkg::t_rgbmf_ctl         i_ctl,
    input  wire logic [7:0]               i_x,
    input  rgbmf_pkg::t_rgbmf_link        i_left,
    input  rgbmf_pkg::t_rgbmf_link        i_right,
    output rgbmf_pkg::t_rgbmf_link        o_link
);
    import rgbmf_pkg::*;

    logic              r_vld;
    logic [CHAN_W-1:0] r_val;
    logic              w_gt;

    assign w_gt   = !r_vld || (r_val > i_x);
    assign o_link = '{vld: r_vld, val: r_val, gt: w_gt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_vld <= 1'b0;
        end else if (i_ctl.ins && w_gt) begin
            r_vld <= i_left.gt ? i_left.vld : 1'b1;
        end else if (i_ctl.shf) begin
            r_vld <= i_right.vld;
        end
    end

    // open a slot: take the left value, or the new one where the gap is here
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && w_gt) begin
            r_val <= i_left.gt ? i_left.val : i_x;
        end else if (i_ctl.shf) begin
            r_val <= i_right.val;
        end
    end

endmodule

`default_nettype wire

>>> design/rgbmf_chain.sv
// ----------------------------------------------------------------------------
// rgbmf_chain
// Row of sorting cells for one colour channel; shows its two lowest cells.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbmf_chain #(
    parameter int DEPTH = rgbmf_pkg::DEF_MAX_WINDOW * rgbmf_pkg::DEF_MAX_WINDOW
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  rgbmf_pkg::t_rgbmf_ctl  i_ctl,
    input  wire logic [7:0]        i_x,
    output logic [7:0]             o_lo0,
    output logic [7:0]             o_lo1
);
    import rgbmf_pkg::*;

    t_rgbmf_link w_link [DEPTH+2];   // [0] left edge, [DEPTH+1] right edge

    assign w_link[0]       = '{vld: 1'b1, val: '0, gt: 1'b0};
    assign w_link[DEPTH+1] = '{vld: 1'b0, val: '0, gt: 1'b1};

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        rgbmf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (i_ctl),
            .i_x     (i_x),
            .i_left  (w_link[g]),
            .i_right (w_link[g+2]),
            .o_link  (w_link[g+1])
        );
    end

    assign o_lo0 = w_link[1].val;
    assign o_lo1 = w_link[2].val;

endmodule

`default_nettype wire

>>> design/rgb_window_median_filter.sv
// ----------------------------------------------------------------------------
// rgb_window_median_filter
// Frame store plus per-channel insertion sorting chains for a clipped median.
// ----------------------------------------------------------------------------
// Load: taken whenever idle, writes the frame store at once.
// Query: a setup, store reads of the n clipped window pixels (n up to 49),
//   a drain, then (n-1)/2 shifts and the result, held off by an output stall.
//   A query outside the image skips to a zero result. The single store read
//   port reads one pixel per cycle; items are taken one at a time.
// Reset (synchronous, active low) empties the chains and the output, and
//   restores the registers to 128, 128, 3. The store itself is not cleared.
`default_nettype none

module rgb_window_median_filter #(
    parameter int MAX_WIDTH  = rgbmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rgbmf_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WINDOW = rgbmf_pkg::DEF_MAX_WINDOW
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  rgbmf_pkg::t_rgbmf_in                   i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output rgbmf_pkg::t_rgbmf_out                  o_out_data,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [rgbmf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [rgbmf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import rgbmf_pkg::*;

    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WIN_CAP = MAX_WINDOW * MAX_WINDOW;
    localparam int NW      = $clog2(WIN_CAP + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_SHIFT = 2'd3;

    // configuration registers
    logic [DIM_W-1:0] r_img_width, r_img_height;
    logic [WIN_W-1:0] r_win_size;

    // sequencer
    logic [1:0]       r_state;
    logic [DIM_W-1:0] r_cx, r_cy, r_x0, r_x1, r_y1;
    logic [NW-1:0]    r_cnt;      // pixels read for this query
    logic [NW-1:0]    r_shift;    // shifts left before the result
    logic             r_zero;     // query outside the image
    logic             r_drain2;   // second drain cycle

    // store read path
    logic [23:0]      r_mem [DEPTH];
    logic [23:0]      r_rd_data;
    logic             r_rd_vld;

    logic             r_out_vld;
    t_rgbmf_out       r_out;

    logic             w_in_acc, w_slot_free, w_issue, w_last;
    logic [DIM_W-1:0] w_w, w_h, w_px, w_py, w_r, w_x0, w_x1, w_y0, w_y1;
    logic [WIN_W-1:0] w_ws;
    logic [AW-1:0]    w_waddr, w_raddr;
    t_rgbmf_ctl       w_ctl;
    logic [7:0]       w_r0, w_r1, w_g0, w_g1, w_b0, w_b1;
    logic [8:0]       w_rs, w_gs, w_bs;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_slot_free = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_width  <= RST_IMG_WIDTH;
            r_img_height <= RST_IMG_HEIGHT;
            r_win_size   <= RST_WIN_SIZE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMG_WIDTH:  r_img_width  <= i_cfg_data;
                CFG_IMG_HEIGHT: r_img_height <= i_cfg_data;
                CFG_WIN_SIZE:   r_win_size   <= i_cfg_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp dimensions and window; zero acts as one, large values saturate.
    always_comb begin
        if (r_img_width == '0)                     w_w = DIM_W'(1);
        else if (32'(r_img_width) > MAX_WIDTH)     w_w = DIM_W'(MAX_WIDTH);
        else                                       w_w = r_img_width;
        if (r_img_height == '0)                    w_h = DIM_W'(1);
        else if (32'(r_img_height) > MAX_HEIGHT)   w_h = DIM_W'(MAX_HEIGHT);
        else                                       w_h = r_img_height;
        if (r_win_size == '0)                      w_ws = WIN_W'(1);
        else if (32'(r_win_size) > MAX_WINDOW)     w_ws = WIN_W'(MAX_WINDOW);
        else                                       w_ws = r_win_size;
    end

    // Window corners, clipped at the image borders.
    assign w_px = DIM_W'(i_in_data.pos_x);
    assign w_py = DIM_W'(i_in_data.pos_y);
    assign w_r  = DIM_W'(w_ws >> 1);
    assign w_x0 = (w_px >= w_r) ? w_px - w_r : '0;
    assign w_y0 = (w_py >= w_r) ? w_py - w_r : '0;
    assign w_x1 = (w_px + w_r < w_w - 1'b1) ? w_px + w_r : w_w - 1'b1;
    assign w_y1 = (w_py + w_r < w_h - 1'b1) ? w_py + w_r : w_h - 1'b1;

    assign w_waddr = AW'(32'(i_in_data.pos_y) * MAX_WIDTH + 32'(i_in_data.pos_x));
    assign w_raddr = AW'(32'(r_cy) * MAX_WIDTH + 32'(r_cx));

    assign w_issue = (r_state == S_READ);
    assign w_last  = (r_cx == r_x1) && (r_cy == r_y1);

    // Frame store: one write port for loads, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_in_data.op == OP_LOAD
                && 32'(i_in_data.pos_x) < MAX_WIDTH
                && 32'(i_in_data.pos_y) < MAX_HEIGHT) begin
            r_mem[w_waddr] <= {i_in_data.in_red, i_in_data.in_green, i_in_data.in_blue};
        end
        r_rd_data <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= w_issue;
        end
    end

    // Sequencer: scan the window row by row, drain, shift to the middle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_shift  <= '0;
            r_zero   <= 1'b0;
            r_drain2 <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && i_in_data.op == OP_QUERY) begin
                        r_cnt    <= '0;
                        r_drain2 <= 1'b0;
                        if (w_px >= w_w || w_py >= w_h) begin
                            // outside the image: answer zero without reading the store
                            r_zero  <= 1'b1;
                            r_shift <= '0;
                            r_state <= S_SHIFT;
                        end else begin
                            r_zero  <= 1'b0;
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (w_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    // hold until the last read has entered the chains
                    r_drain2 <= 1'b1;
                    if (r_drain2) begin
                        r_shift <= (r_cnt - 1'b1) >> 1;
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (r_shift != '0) begin
                        r_shift <= r_shift - 1'b1;
                    end else if (w_slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_in_acc) begin
            r_cx <= w_x0;
            r_cy <= w_y0;
            r_x0 <= w_x0;
            r_x1 <= w_x1;
            r_y1 <= w_y1;
        end else if (w_issue) begin
            if (r_cx == r_x1) begin
                r_cx <= r_x0;
                r_cy <= r_cy + 1'b1;
            end else begin
                r_cx <= r_cx + 1'b1;
            end
        end
    end

    // Chains: clear on any accepted item, insert each read pixel, then shift down.
    assign w_ctl.clr = (r_state == S_IDLE) && w_in_acc;
    assign w_ctl.ins = r_rd_vld;
    assign w_ctl.shf = (r_state == S_SHIFT) && (r_shift != '0);

    rgbmf_chain #(.DEPTH(WIN_CAP)) u_red (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctl (w_ctl),
        .i_x   (r_rd_data[23:16]), .o_lo0 (w_r0), .o_lo1 (w_r1)
    );
    rgbmf_chain #(.DEPTH(WIN_CAP)) u_green (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctl (w_ctl),
        .i_x   (r_rd_data[15:8]), .o_lo0 (w_g0), .o_lo1 (w_g1)
    );
    rgbmf_chain #(.DEPTH(WIN_CAP)) u_blue (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctl (w_ctl),
        .i_x   (r_rd_data[7:0]), .o_lo0 (w_b0), .o_lo1 (w_b1)
    );

    // Even count: floored mean of the two middle values.
    assign w_rs = 9'(w_r0) + 9'(w_r1);
    assign w_gs = 9'(w_g0) + 9'(w_g1);
    assign w_bs = 9'(w_b0) + 9'(w_b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == S_SHIFT && r_shift == '0 && w_slot_free) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SHIFT && r_shift == '0 && w_slot_free) begin
            if (r_zero) begin
                r_out <= '0;
            end else if (r_cnt[0]) begin
                r_out <= '{out_red: w_r0, out_green: w_g0, out_blue: w_b0};
            end else begin
                r_out <= '{out_red: w_rs[8:1], out_green: w_gs[8:1], out_blue: w_bs[8:1]};
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> design/rgbmf_checker.sv
// ----------------------------------------------------------------------------
// rgbmf_checker
// Port-level checks of the RGB window median filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbmf_checker (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_in_valid,
    input wire logic                   o_in_stall,
    input rgbmf_pkg::t_rgbmf_in        i_in_data,
    input wire logic                   o_out_valid,
    input wire logic                   i_out_stall,
    input rgbmf_pkg::t_rgbmf_out       o_out_data
);
    import rgbmf_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.op == OP_QUERY |=> o_in_stall)
        else $error("query accepted without going busy");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.op == OP_LOAD && !o_out_valid
        |=> !o_out_valid)
        else $error("load produced a result");

endmodule

bind rgb_window_median_filter rgbmf_checker u_rgbmf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
